@@ sv/fked_pkg.sv @@
package fked_pkg;

  localparam int unsigned MAX_CHUNK_DEF = 8;
  localparam int unsigned DEC_LEN       = 7;
  localparam int unsigned LEN_W         = 5;
  localparam int unsigned CODE_W        = 11;

  localparam logic [7:0] ESC_BYTE  = 8'o033;
  localparam logic [7:0] LBRACKET  = 8'o133;
  localparam logic [7:0] LETTER_O  = 8'o117;
  localparam logic [7:0] LETTER_P  = 8'o120;
  localparam logic [7:0] LETTER_S  = 8'o123;
  localparam logic [7:0] TILDE     = 8'o176;
  localparam logic [7:0] SEMICOLON = 8'o073;
  localparam logic [7:0] DIGIT_0   = 8'o060;
  localparam logic [7:0] DIGIT_1   = 8'o061;
  localparam logic [7:0] DIGIT_2   = 8'o062;
  localparam logic [7:0] DIGIT_3   = 8'o063;
  localparam logic [7:0] DIGIT_4   = 8'o064;
  localparam logic [7:0] DIGIT_5   = 8'o065;
  localparam logic [7:0] DIGIT_6   = 8'o066;
  localparam logic [7:0] DIGIT_7   = 8'o067;
  localparam logic [7:0] DIGIT_8   = 8'o070;
  localparam logic [7:0] DIGIT_9   = 8'o071;

  localparam logic [CODE_W-1:0] KEY_RUBOUT = 11'o177;
  localparam logic [CODE_W-1:0] KEY_F1     = 11'd1000;
  localparam logic [CODE_W-1:0] KEY_F5     = 11'd1004;
  localparam logic [CODE_W-1:0] KEY_F6     = 11'd1005;
  localparam logic [CODE_W-1:0] KEY_F7     = 11'd1006;
  localparam logic [CODE_W-1:0] KEY_F8     = 11'd1007;
  localparam logic [CODE_W-1:0] KEY_F9     = 11'd1008;
  localparam logic [CODE_W-1:0] KEY_F10    = 11'd1009;
  localparam logic [CODE_W-1:0] KEY_F11    = 11'd1010;
  localparam logic [CODE_W-1:0] KEY_F12    = 11'd1011;
  localparam logic [CODE_W-1:0] KEY_SF1    = 11'd1012;
  localparam logic [CODE_W-1:0] KEY_SF3    = 11'd1014;
  localparam logic [CODE_W-1:0] KEY_SF4    = 11'd1015;
  localparam logic [CODE_W-1:0] KEY_SF5    = 11'd1016;
  localparam logic [CODE_W-1:0] KEY_SF6    = 11'd1017;
  localparam logic [CODE_W-1:0] KEY_SF7    = 11'd1018;
  localparam logic [CODE_W-1:0] KEY_SF8    = 11'd1019;
  localparam logic [CODE_W-1:0] KEY_SF9    = 11'd1020;
  localparam logic [CODE_W-1:0] KEY_SF10   = 11'd1021;
  localparam logic [CODE_W-1:0] KEY_SF11   = 11'd1022;
  localparam logic [CODE_W-1:0] KEY_SF12   = 11'd1023;
  localparam logic [CODE_W-1:0] KEY_CF1    = 11'd1024;

  typedef logic [7:0] byte_arr_t [DEC_LEN];

  typedef struct packed {
    logic              found;
    logic [CODE_W-1:0] code;
  } key_t;

  function automatic key_t hit(input logic [CODE_W-1:0] code);
    key_t r;
    r.found = 1'b1;
    r.code  = code;
    return r;
  endfunction

  function automatic logic is_fn_letter(input logic [7:0] b);
    return (b >= LETTER_P) && (b <= LETTER_S);
  endfunction

  function automatic key_t decode_chunk(input byte_arr_t c, input logic [LEN_W-1:0] n);
    key_t r;
    logic [7:0] k;
    r = '0;
    k = c[3];
    if (n == LEN_W'(1)) begin
      r = hit({3'b000, c[0]});
    end else if (n >= LEN_W'(3) && c[0] == ESC_BYTE) begin
      if (n == LEN_W'(3) && c[1] == LETTER_O) begin
        if (is_fn_letter(c[2])) r = hit(KEY_F1 + CODE_W'(c[2][1:0]));
      end else if (c[1] == LBRACKET) begin
        if (n == LEN_W'(4) && c[2] == DIGIT_3 && c[3] == TILDE) begin
          r = hit(KEY_RUBOUT);
        end else if (n == LEN_W'(5) && c[4] == TILDE) begin
          case (c[2])
            DIGIT_1: begin
              case (k)
                DIGIT_5: r = hit(KEY_F5);
                DIGIT_7: r = hit(KEY_F6);
                DIGIT_8: r = hit(KEY_F7);
                DIGIT_9: r = hit(KEY_F8);
                default: r = '0;
              endcase
            end
            DIGIT_2: begin
              case (k)
                DIGIT_0: r = hit(KEY_F9);
                DIGIT_1: r = hit(KEY_F10);
                DIGIT_3: r = hit(KEY_F11);
                DIGIT_4: r = hit(KEY_F12);
                DIGIT_5: r = hit(KEY_SF3);
                DIGIT_6: r = hit(KEY_SF4);
                DIGIT_8: r = hit(KEY_SF5);
                DIGIT_9: r = hit(KEY_SF6);
                default: r = '0;
              endcase
            end
            DIGIT_3: begin
              case (k)
                DIGIT_1: r = hit(KEY_SF7);
                DIGIT_2: r = hit(KEY_SF8);
                DIGIT_3: r = hit(KEY_SF9);
                DIGIT_4: r = hit(KEY_SF10);
                default: r = '0;
              endcase
            end
            DIGIT_4: begin
              case (k)
                DIGIT_2: r = hit(KEY_SF11);
                DIGIT_3: r = hit(KEY_SF12);
                default: r = '0;
              endcase
            end
            default: r = '0;
          endcase
        end else if (n == LEN_W'(6) && c[2] == DIGIT_1 && c[3] == SEMICOLON) begin
          if (is_fn_letter(c[5])) begin
            if (c[4] == DIGIT_5)      r = hit(KEY_CF1 + CODE_W'(c[5][1:0]));
            else if (c[4] == DIGIT_2) r = hit(KEY_SF1 + CODE_W'(c[5][1:0]));
          end
        end else if (n == LEN_W'(7) && c[4] == SEMICOLON && c[5] == DIGIT_2
                     && c[6] == TILDE) begin
          if (c[2] == DIGIT_1) begin
            case (k)
              DIGIT_5: r = hit(KEY_SF5);
              DIGIT_7: r = hit(KEY_SF6);
              DIGIT_8: r = hit(KEY_SF7);
              DIGIT_9: r = hit(KEY_SF8);
              default: r = '0;
            endcase
          end else if (c[2] == DIGIT_2) begin
            case (k)
              DIGIT_0: r = hit(KEY_SF9);
              DIGIT_1: r = hit(KEY_SF10);
              DIGIT_3: r = hit(KEY_SF11);
              DIGIT_4: r = hit(KEY_SF12);
              default: r = '0;
            endcase
          end
        end
      end
    end
    return r;
  endfunction

endpackage

@@ sv/function_key_escape_decoder_top.sv @@
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tdata[7:0] rx_byte, tlast end_of_chunk
// m_axis    out  m_axis_tvalid/tready        tdata[10:0] key_code, tuser key_found
//
// One byte per cycle while the input is not stalled; the chunk's last byte is taken
// into the input register, then decoded into the result register.
// Reset clears the byte count, the overflow flag and both valid flags.
// Input stalls only while a last byte waits in the input register behind an
// unread result.
module function_key_escape_decoder_top
  import fked_pkg::*;
#(
  parameter int unsigned MaxChunk = MAX_CHUNK_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tlast,   // end_of_chunk
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [10:0] key_code, [15:11] zero
  output logic        m_axis_tuser    // key_found
);

  localparam int unsigned CntW = $clog2(MaxChunk + 1);
  localparam int unsigned IdxW = $clog2(MaxChunk);

  logic            in_valid_q, in_valid_d;
  logic [7:0]      in_byte_q;
  logic            in_last_q;
  logic [CntW-1:0] count_q, count_d;
  logic            over_q, over_d;
  logic [7:0]      buf_q [MaxChunk];
  logic            out_valid_q, out_valid_d;
  key_t            out_key_q;

  logic            s_accept;
  logic            advance;
  logic            room;
  logic            load_out;
  logic [CntW-1:0] len;
  logic            over_now;
  byte_arr_t       view;
  key_t            dec_key;

  assign advance       = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign room          = count_q < CntW'(MaxChunk);
  assign load_out      = advance && in_last_q;
  assign len           = room ? count_q + CntW'(1) : count_q;
  assign over_now      = over_q || !room;

  always_comb begin
    for (int i = 0; i < DEC_LEN; i++) begin
      if (CntW'(i) < count_q)       view[i] = buf_q[i];
      else if (CntW'(i) == count_q) view[i] = in_byte_q;
      else                          view[i] = 8'h00;
    end
    dec_key = over_now ? key_t'('0) : decode_chunk(view, LEN_W'(len));
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept)     in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
    count_d = count_q;
    over_d  = over_q;
    if (advance) begin
      if (in_last_q) begin
        count_d = '0;
        over_d  = 1'b0;
      end else if (room) begin
        count_d = count_q + CntW'(1);
      end else begin
        over_d = 1'b1;
      end
    end
    out_valid_d = out_valid_q;
    if (load_out)           out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      count_q     <= '0;
      over_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      count_q     <= count_d;
      over_q      <= over_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance && !in_last_q && room) begin
      buf_q[count_q[IdxW-1:0]] <= in_byte_q;
    end
    if (load_out) begin
      out_key_q <= dec_key;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(16 - CODE_W)'(0), out_key_q.code};
  assign m_axis_tuser  = out_key_q.found;

endmodule

@@ verif/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fked_pkg::*;

  typedef struct packed {
    logic              found;
    logic [CODE_W-1:0] code;
  } key_res_t;

  typedef enum int unsigned {
    FAM_SINGLE, FAM_SS3, FAM_RUBOUT, FAM_TILDE, FAM_MOD_LETTER, FAM_MOD_TILDE
  } seq_family_e;

  typedef enum int unsigned {
    MUT_CORRUPT, MUT_TRUNCATE, MUT_EXTEND, MUT_NOISE, MUT_OVERLONG
  } seq_damage_e;

  localparam int unsigned      IDLE_LIMIT   = 2000;
  localparam int unsigned      ITEMS_IDLING = 1250;
  localparam int unsigned      ITEMS_TOTAL  = 1650;
  localparam logic [CODE_W-1:0] SHIFT_OFS   = KEY_SF1 - KEY_F1;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] rx_byte
  logic        s_axis_tlast  = 1'b0;    // end_of_chunk
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;            // [10:0] key_code, [15:11] zero
  logic        m_axis_tuser;            // key_found

  logic [7:0] held_bytes [MAX_CHUNK_DEF];
  int         held_count = 0;
  bit         held_over  = 1'b0;
  key_res_t   pending_keys [$];
  key_res_t   want_key;
  logic [7:0] chunk_q [$];

  bit src_idle  = 1'b1;
  bit sink_idle = 1'b1;
  int stall_left    = 0;
  int quiet_cycles  = 0;
  int bytes_sent    = 0;
  int chunks_sent   = 0;
  int results_seen  = 0;
  int keys_found    = 0;
  int mismatches    = 0;

  function_key_escape_decoder_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CODE_W-1:0] tilde_key(input logic [7:0] lead, input logic [7:0] k);
    case (lead)
      DIGIT_1: begin
        case (k)
          DIGIT_5: return KEY_F5;
          DIGIT_7: return KEY_F6;
          DIGIT_8: return KEY_F7;
          DIGIT_9: return KEY_F8;
          default: return '0;
        endcase
      end
      DIGIT_2: begin
        case (k)
          DIGIT_0: return KEY_F9;
          DIGIT_1: return KEY_F10;
          DIGIT_3: return KEY_F11;
          DIGIT_4: return KEY_F12;
          DIGIT_5: return KEY_SF3;
          DIGIT_6: return KEY_SF4;
          DIGIT_8: return KEY_SF5;
          DIGIT_9: return KEY_SF6;
          default: return '0;
        endcase
      end
      DIGIT_3: begin
        case (k)
          DIGIT_1: return KEY_SF7;
          DIGIT_2: return KEY_SF8;
          DIGIT_3: return KEY_SF9;
          DIGIT_4: return KEY_SF10;
          default: return '0;
        endcase
      end
      DIGIT_4: begin
        case (k)
          DIGIT_2: return KEY_SF11;
          DIGIT_3: return KEY_SF12;
          default: return '0;
        endcase
      end
      default: return '0;
    endcase
  endfunction

  function automatic key_res_t decode_held(input logic [7:0] c [MAX_CHUNK_DEF], input int n);
    key_res_t          r;
    logic [CODE_W-1:0] base;
    r = '0;
    if (n == 1) begin
      r = {1'b1, 3'b000, c[0]};
    end else if (n >= 3 && c[0] == ESC_BYTE) begin
      if (n == 3 && c[1] == LETTER_O) begin
        if (c[2] >= LETTER_P && c[2] <= LETTER_S) r = {1'b1, KEY_F1 + CODE_W'(c[2] - LETTER_P)};
      end else if (c[1] == LBRACKET) begin
        if (n == 4 && c[2] == DIGIT_3 && c[3] == TILDE) begin
          r = {1'b1, KEY_RUBOUT};
        end else if (n == 5 && c[4] == TILDE) begin
          base = tilde_key(c[2], c[3]);
          if (base != '0) r = {1'b1, base};
        end else if (n == 6 && c[2] == DIGIT_1 && c[3] == SEMICOLON) begin
          if (c[5] >= LETTER_P && c[5] <= LETTER_S) begin
            if (c[4] == DIGIT_5)      r = {1'b1, KEY_CF1 + CODE_W'(c[5] - LETTER_P)};
            else if (c[4] == DIGIT_2) r = {1'b1, KEY_SF1 + CODE_W'(c[5] - LETTER_P)};
          end
        end else if (n == 7 && c[4] == SEMICOLON && c[5] == DIGIT_2 && c[6] == TILDE) begin
          // modified tilde form: plain F5-F12 shifted up by twelve
          base = tilde_key(c[2], c[3]);
          if (base >= KEY_F5 && base <= KEY_F12) r = {1'b1, base + SHIFT_OFS};
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    if (held_count < MAX_CHUNK_DEF) begin
      held_bytes[held_count] = b;
      held_count++;
    end else begin
      held_over = 1'b1;
    end
    if (last) begin
      pending_keys.push_back(held_over ? key_res_t'('0) : decode_held(held_bytes, held_count));
      held_count = 0;
      held_over  = 1'b0;
      chunks_sent++;
    end
    gap = src_idle ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_chunk();
    foreach (chunk_q[i]) send_byte(chunk_q[i], i == chunk_q.size() - 1);
  endtask

  task automatic build_chunk(input bit damaged);
    seq_family_e fam;
    seq_damage_e dmg;
    int          p;
    fam = seq_family_e'($urandom_range(0, 5));
    chunk_q.delete();
    case (fam)
      FAM_SINGLE:  chunk_q = '{8'($urandom)};
      FAM_SS3:     chunk_q = '{ESC_BYTE, LETTER_O, LETTER_P + 8'($urandom_range(0, 3))};
      FAM_RUBOUT:  chunk_q = '{ESC_BYTE, LBRACKET, DIGIT_3, TILDE};
      FAM_TILDE: begin
        chunk_q = '{ESC_BYTE, LBRACKET, DIGIT_1 + 8'($urandom_range(0, 3)),
                    DIGIT_0 + 8'($urandom_range(0, 9)), TILDE};
      end
      FAM_MOD_LETTER: begin
        chunk_q = '{ESC_BYTE, LBRACKET, DIGIT_1, SEMICOLON,
                    $urandom_range(0, 1) ? DIGIT_5 : DIGIT_2,
                    LETTER_P + 8'($urandom_range(0, 3))};
      end
      default: begin
        chunk_q = '{ESC_BYTE, LBRACKET, DIGIT_1 + 8'($urandom_range(0, 1)),
                    DIGIT_0 + 8'($urandom_range(0, 9)), SEMICOLON, DIGIT_2, TILDE};
      end
    endcase
    if (!damaged) return;
    dmg = seq_damage_e'($urandom_range(0, 4));
    case (dmg)
      MUT_CORRUPT: begin
        p = $urandom_range(0, chunk_q.size() - 1);
        if ($urandom_range(0, 1)) chunk_q[p] = 8'($urandom);
        else chunk_q[p] = $urandom_range(0, 1) ? chunk_q[p] + 8'd1 : chunk_q[p] - 8'd1;
      end
      MUT_TRUNCATE: begin
        if (chunk_q.size() > 1) void'(chunk_q.pop_back());
        else chunk_q.push_back(8'($urandom));
      end
      MUT_EXTEND: chunk_q.push_back($urandom_range(0, 1) ? TILDE : 8'($urandom));
      MUT_NOISE: begin
        chunk_q.delete();
        repeat ($urandom_range(2, 8)) chunk_q.push_back(8'($urandom));
        if ($urandom_range(0, 1)) chunk_q[0] = ESC_BYTE;
      end
      default: begin
        p = $urandom_range(MAX_CHUNK_DEF, 20);
        while (chunk_q.size() < p) chunk_q.push_back(8'($urandom));
      end
    endcase
  endtask

  task automatic test_single_bytes();
    chunk_q = '{8'h00};
    send_chunk();
    chunk_q = '{8'hFF};
    send_chunk();
  endtask

  task automatic test_escape_keys();
    chunk_q = '{ESC_BYTE, LETTER_O, LETTER_S};
    send_chunk();
    chunk_q = '{ESC_BYTE, LBRACKET, DIGIT_3, TILDE};
    send_chunk();
    chunk_q = '{ESC_BYTE, LBRACKET, DIGIT_1, SEMICOLON, DIGIT_5, LETTER_P};
    send_chunk();
    chunk_q = '{ESC_BYTE, LBRACKET, DIGIT_1, DIGIT_5, SEMICOLON, DIGIT_2, TILDE};
    send_chunk();
    chunk_q = '{ESC_BYTE, LETTER_O, LETTER_S + 8'd1};
    send_chunk();
  endtask

  task automatic test_random_keys(input int unsigned target, input bit idling);
    src_idle  = idling;
    sink_idle = idling;
    while (bytes_sent < target) begin
      build_chunk($urandom_range(0, 99) < 25);
      send_chunk();
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_idle && $urandom_range(0, 3) == 0) begin
      stall_left    <= pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_keys.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, tdata %0d tuser %0b",
                                  m_axis_tdata, m_axis_tuser));
      end else begin
        want_key = pending_keys.pop_front();
        if (want_key.found) keys_found++;
        if (m_axis_tdata !== {5'b00000, want_key.code})
          report_mismatch($sformatf("result %0d key_code got %0d want %0d",
                                    results_seen, m_axis_tdata, want_key.code));
        if (m_axis_tuser !== want_key.found)
          report_mismatch($sformatf("result %0d key_found got %0b want %0b",
                                    results_seen, m_axis_tuser, want_key.found));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_bytes();
    test_escape_keys();
    test_random_keys(ITEMS_IDLING, 1'b1);
    test_random_keys(ITEMS_TOTAL, 1'b0);
    s_axis_tvalid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("%0d chunks in %0d bytes decoded, %0d results checked", chunks_sent, bytes_sent,
             results_seen);
    $display("%0d keys recognized, %0d unknown or overlong", keys_found,
             results_seen - keys_found);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
